FILE: hdl/sdt_pkg.sv
// shared types and constants for the seen device table
`default_nettype none
package sdt_pkg;

  localparam int unsigned EntryCountDef = 24;
  localparam int unsigned SlotW         = 5;
  localparam logic [31:0] WindowMin     = 32'd1000;
  localparam logic [31:0] WindowMax     = 32'd60000;

  localparam logic [1:0] CmdAdvert = 2'd0;
  localparam logic [1:0] CmdStart  = 2'd1;
  localparam logic [1:0] CmdRead   = 2'd2;

  typedef struct packed {
    logic [1:0]        command;
    logic [31:0]       now_time;
    logic [47:0]       device_address;
    logic [7:0]        address_kind;
    logic signed [7:0] signal_strength;
    logic [31:0]       window_length;
    logic [4:0]        read_index;
  } req_t;

  typedef struct packed {
    logic              accepted;
    logic              matched;
    logic [4:0]        written_slot;
    logic              entry_used;
    logic [47:0]       entry_address;
    logic [7:0]        entry_kind;
    logic signed [7:0] entry_strength;
    logic [31:0]       entry_last_seen;
  } rsp_t;

  typedef struct packed {
    logic              used;
    logic [47:0]       address;
    logic [7:0]        kind;
    logic signed [7:0] strength;
    logic [31:0]       seen;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

endpackage
`default_nettype wire

FILE: hdl/sdt_cell.sv
// one table entry of the circulating chain
`default_nettype none
module sdt_cell
  import sdt_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cell_ctl_t ctl_i,
  input  wire entry_t    entry_i,
  output entry_t         entry_o
);

  entry_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.clear) begin
      entry_d = '0;
    end else if (ctl_i.shift) begin
      entry_d = entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule
`default_nettype wire

FILE: hdl/seen_device_table_lru.sv
// top level: controller and the chain of table cells
// The table is a ring of ENTRY_COUNT cells that rotates one place per cycle
// while an operation runs; the controller looks only at the head cell and
// feeds the tail. An advertisement is launched, makes one rotation to search
// for a match, a free entry and the oldest entry and one rotation to write
// the chosen entry, and is then posted; a read is launched, makes one rotation
// and is posted. A start command, an unknown command, an advertisement
// outside the learning window or a read beyond the table is answered from
// the idle state. Items are taken one at a time; a result left waiting in
// the output register holds off the next item until it has been taken.
`default_nettype none
module seen_device_table_lru
  import sdt_pkg::*;
#(
  parameter int unsigned ENTRY_COUNT = EntryCountDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire req_t in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output rsp_t      out_data_o
);

  localparam int unsigned IW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int unsigned CW = (IW + 1 > SlotW) ? IW + 1 : SlotW;
  localparam logic [IW-1:0] LastIdx = IW'(ENTRY_COUNT - 1);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StScan  = 3'd1;
  localparam logic [2:0] StWrite = 3'd2;
  localparam logic [2:0] StRead  = 3'd3;
  localparam logic [2:0] StFin   = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [IW-1:0] cnt_q, cnt_d;
  req_t          req_q, req_d;
  logic [31:0]   dl_q, dl_d;
  logic          hit_q, hit_d;
  logic          free_ok_q, free_ok_d;
  logic [IW-1:0] free_q, free_d;
  logic [IW-1:0] old_q, old_d;
  logic [31:0]   old_time_q, old_time_d;
  logic [IW-1:0] slot_q, slot_d;
  entry_t        rd_q, rd_d;
  logic          out_valid_q, out_valid_d;
  rsp_t          out_q, out_d;

  cell_ctl_t     ctl;
  entry_t        chain [ENTRY_COUNT];
  entry_t        head, tail, fresh;

  logic          accept, out_block, in_range, in_window;
  logic [31:0]   dur;
  logic [32:0]   dl_sum;

  assign head       = chain[0];
  assign out_block  = out_valid_q && out_stall_i;
  assign in_stall_o = (state_q != StIdle) || out_block;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_range   = CW'(in_data_i.read_index) < CW'(ENTRY_COUNT);
  assign in_window  = in_data_i.now_time < dl_q;

  always_comb begin
    dur = in_data_i.window_length;
    if (dur < WindowMin) dur = WindowMin;
    if (dur > WindowMax) dur = WindowMax;
    dl_sum = {1'b0, in_data_i.now_time} + {1'b0, dur};
  end

  always_comb begin
    fresh.used     = 1'b1;
    fresh.address  = req_q.device_address;
    fresh.kind     = req_q.address_kind;
    fresh.strength = req_q.signal_strength;
    fresh.seen     = req_q.now_time;
    tail = head;
    if (state_q == StWrite && cnt_q == slot_q) tail = fresh;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    req_d       = req_q;
    dl_d        = dl_q;
    hit_d       = hit_q;
    free_ok_d   = free_ok_q;
    free_d      = free_q;
    old_d       = old_q;
    old_time_d  = old_time_q;
    slot_d      = slot_q;
    rd_d        = rd_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    ctl.shift   = 1'b0;
    ctl.clear   = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          req_d     = in_data_i;
          cnt_d     = '0;
          hit_d     = 1'b0;
          free_ok_d = 1'b0;
          rd_d      = '0;
          out_d     = '0;
          unique case (in_data_i.command)
            CmdAdvert: begin
              if (in_window) begin
                state_d = StScan;
              end else begin
                out_valid_d = 1'b1;
              end
            end
            CmdStart: begin
              ctl.clear      = 1'b1;
              dl_d           = dl_sum[32] ? 32'hFFFF_FFFF : dl_sum[31:0];
              out_d.accepted = 1'b1;
              out_valid_d    = 1'b1;
            end
            CmdRead: begin
              if (in_range) begin
                state_d = StRead;
              end else begin
                out_valid_d = 1'b1;
              end
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      StScan: begin
        ctl.shift = 1'b1;
        cnt_d     = cnt_q + 1'b1;
        if (!hit_q) begin
          if (head.used && head.address == req_q.device_address) begin
            hit_d  = 1'b1;
            slot_d = cnt_q;
          end else begin
            if (!head.used && !free_ok_q) begin
              free_ok_d = 1'b1;
              free_d    = cnt_q;
            end
            if (cnt_q == '0 || head.seen < old_time_q) begin
              old_d      = cnt_q;
              old_time_d = head.seen;
            end
          end
        end
        if (cnt_q == LastIdx) begin
          cnt_d   = '0;
          state_d = StWrite;
          if (!hit_d) slot_d = free_ok_d ? free_d : old_d;
        end
      end
      StWrite: begin
        ctl.shift = 1'b1;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == LastIdx) begin
          cnt_d   = '0;
          state_d = StFin;
        end
      end
      StRead: begin
        ctl.shift = 1'b1;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == IW'(req_q.read_index)) rd_d = head;
        if (cnt_q == LastIdx) begin
          cnt_d   = '0;
          state_d = StFin;
        end
      end
      StFin: begin
        if (!out_block) begin
          out_d = '0;
          if (req_q.command == CmdAdvert) begin
            out_d.accepted     = 1'b1;
            out_d.matched      = hit_q;
            out_d.written_slot = SlotW'(slot_q);
          end else begin
            out_d.entry_used      = rd_q.used;
            out_d.entry_address   = rd_q.address;
            out_d.entry_kind      = rd_q.kind;
            out_d.entry_strength  = rd_q.strength;
            out_d.entry_last_seen = rd_q.seen;
          end
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      dl_q        <= '0;
      hit_q       <= 1'b0;
      free_ok_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      dl_q        <= dl_d;
      hit_q       <= hit_d;
      free_ok_q   <= free_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    free_q     <= free_d;
    old_q      <= old_d;
    old_time_q <= old_time_d;
    slot_q     <= slot_d;
    rd_q       <= rd_d;
    out_q      <= out_d;
  end

  // ring: each cell takes from its upper neighbour, the last from the tail feed
  for (genvar g = 0; g < ENTRY_COUNT; g++) begin : g_cell
    entry_t nb;
    if (g == ENTRY_COUNT - 1) begin : g_tail
      assign nb = tail;
    end else begin : g_mid
      assign nb = chain[g+1];
    end
    sdt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .entry_i (nb),
      .entry_o (chain[g])
    );
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != StIdle) || out_valid_q)
    else $error("accepted transaction produced neither work nor result");

  a_write_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWrite) |-> (CW'(slot_q) < CW'(ENTRY_COUNT)))
    else $error("write slot beyond table");

  a_hit_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan && hit_q) |=> hit_q && $stable(slot_q))
    else $error("match lost during search");

endmodule
`default_nettype wire
